[src/gic_pkg.sv]
// Shared constants and types for the GPIO interrupt controller.
`default_nettype none
package gic_pkg;

    localparam int NUM_PINS       = 184;
    localparam int PINS_PER_GROUP = 4;
    localparam int PIN_AW         = $clog2(NUM_PINS);
    localparam int NUM_GROUPS     = (NUM_PINS + PINS_PER_GROUP - 1) / PINS_PER_GROUP;

    localparam logic [7:0] NUM_PINS_W  = 8'(NUM_PINS);
    localparam logic [7:0] MASTER_WORD = 8'd63;
    localparam logic [7:0] SUM_LO_WORD = 8'd190;
    localparam logic [7:0] SUM_HI_WORD = 8'd191;

    // Bit positions within a pin word and the master word
    localparam int B_LEVEL   = 8;
    localparam int B_ACTLO   = 9;
    localparam int B_BOTH    = 10;
    localparam int B_EN      = 11;
    localparam int B_DELIVER = 12;
    localparam int B_RX      = 16;
    localparam int B_STS     = 28;
    localparam int B_EOI     = 29;

    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_EVENT = 2'd2,
        OP_NOP   = 2'd3
    } t_op;

    typedef struct packed {
        logic              en;
        logic [PIN_AW-1:0] addr;
        logic [31:0]       data;
    } t_pin_wr;

endpackage
`default_nettype wire

[src/gic_pin_ram.sv]
// Pin word table: one write and one registered read port, write-through bypass.
`default_nettype none
module gic_pin_ram (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_rd_en,
    input  wire logic [gic_pkg::PIN_AW-1:0] i_rd_addr,
    input  wire gic_pkg::t_pin_wr      i_wr,
    output logic [31:0]                o_rd_data
);
    import gic_pkg::*;

    logic [31:0]         r_mem [NUM_PINS];
    logic [NUM_PINS-1:0] r_valid;
    logic [31:0]         r_q;
    logic                r_q_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr.en) begin
            r_valid[i_wr.addr] <= 1'b1;
        end
    end

    // a write landing on the address being read wins
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_valid <= 1'b0;
        end else if (i_rd_en) begin
            if (i_wr.en && (i_wr.addr == i_rd_addr)) begin
                r_q       <= i_wr.data;
                r_q_valid <= 1'b1;
            end else begin
                r_q       <= r_mem[i_rd_addr];
                r_q_valid <= r_valid[i_rd_addr];
            end
        end
    end

    // never-written entries read as their reset value of zero
    assign o_rd_data = r_q_valid ? r_q : 32'd0;

endmodule
`default_nettype wire

[src/gpio_interrupt_controller_core.sv]
// GPIO controller with per-pin edge/level interrupt detection and a host line.
`default_nettype none
// Takes one item (bus read, bus write or pin level event) in every cycle: busy is
// always low. The result for an item appears on o_read_data and o_irq, marked by
// o_strobe for one cycle, once the item has passed the input and result registers.
// The read port of the pin word table is loaded at the same edge as the input register.
// Results cannot be held off, so take them in the cycle o_strobe is high.
// Items are handled strictly in order.
module gpio_interrupt_controller_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  i_op,
    input  wire logic [7:0]  i_word_index,
    input  wire logic [31:0] i_write_data,
    input  wire logic        i_pin_level,
    output logic             o_strobe,
    output logic [31:0]      o_read_data,
    output logic             o_irq
);
    import gic_pkg::*;

    // input register
    logic        r_v1;
    t_op         r_op;
    logic [7:0]  r_idx;
    logic [31:0] r_wd;
    logic        r_lvl;

    // block state outside the table
    logic [NUM_PINS-1:0] r_sts, n_sts;
    logic [NUM_PINS-1:0] r_dlv, n_dlv;
    logic [31:0]         r_master, n_master;
    logic                r_irq, n_irq;

    // result register
    logic        r_strobe;
    logic [31:0] r_rdata, n_rdata;

    t_pin_wr     w_wr;
    logic [31:0] w_m;
    logic [63:0] w_summary;
    logic        w_accept;

    logic [PIN_AW-1:0] w_pin;
    logic w_pin_ok, w_sts_c, w_dlv_c, w_before;
    logic [31:0] w_wr_word, w_ev_word;
    logic w_wr_active, w_wr_sts;
    logic w_rise, w_fall, w_hit, w_ev_active, w_ev_sts;

    assign busy     = 1'b0;
    assign w_accept = start && !busy;

    gic_pin_ram u_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (w_accept),
        .i_rd_addr (i_word_index[PIN_AW-1:0]),
        .i_wr      (w_wr),
        .o_rd_data (w_m)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op  <= t_op'(i_op);
            r_idx <= i_word_index;
            r_wd  <= i_write_data;
            r_lvl <= i_pin_level;
        end
    end

    // group summary: status AND deliver, four pins to a bit, pin 63 has no word
    always_comb begin
        w_summary = '0;
        for (int g = 0; g < NUM_GROUPS; g++) begin
            for (int k = 0; k < PINS_PER_GROUP; k++) begin
                if ((g * PINS_PER_GROUP + k < NUM_PINS)
                        && (g * PINS_PER_GROUP + k != int'(MASTER_WORD))) begin
                    if (r_sts[g * PINS_PER_GROUP + k] && r_dlv[g * PINS_PER_GROUP + k]) begin
                        w_summary[g] = 1'b1;
                    end
                end
            end
        end
    end

    assign w_pin    = r_idx[PIN_AW-1:0];
    assign w_pin_ok = (r_idx < NUM_PINS_W) && (r_idx != MASTER_WORD);
    assign w_sts_c  = r_sts[w_pin];
    assign w_dlv_c  = r_dlv[w_pin];
    assign w_before = w_sts_c && w_dlv_c;

    // bus write to a pin word: live level kept, status write-one-to-clear
    always_comb begin
        w_wr_word          = r_wd;
        w_wr_word[B_RX]    = w_m[B_RX];
        w_wr_word[B_STS]   = 1'b0;
    end
    assign w_wr_active = r_wd[B_ACTLO] ? !w_m[B_RX] : w_m[B_RX];
    assign w_wr_sts    = (w_sts_c && !r_wd[B_STS])
                       || (r_wd[B_EN] && r_wd[B_LEVEL] && w_wr_active);

    // pin level event
    assign w_rise      = !w_m[B_RX] && r_lvl;
    assign w_fall      = w_m[B_RX] && !r_lvl;
    assign w_hit       = w_m[B_BOTH] ? (w_rise || w_fall) : (w_m[B_ACTLO] ? w_fall : w_rise);
    assign w_ev_active = w_m[B_ACTLO] ? !r_lvl : r_lvl;
    assign w_ev_sts    = w_sts_c || (w_m[B_EN] && (w_m[B_LEVEL] ? w_ev_active : w_hit));
    always_comb begin
        w_ev_word       = w_m;
        w_ev_word[B_RX] = r_lvl;
    end

    always_comb begin
        n_rdata  = '0;
        n_irq    = r_irq;
        n_sts    = r_sts;
        n_dlv    = r_dlv;
        n_master = r_master;
        w_wr     = '0;
        if (r_v1) begin
            case (r_op)
                OP_READ: begin
                    if (w_pin_ok) begin
                        n_rdata            = w_m;
                        n_rdata[B_DELIVER] = w_dlv_c;
                        n_rdata[B_STS]     = w_sts_c;
                    end else if (r_idx == MASTER_WORD) begin
                        n_rdata = r_master;
                    end else if (r_idx == SUM_LO_WORD) begin
                        n_rdata = w_summary[31:0];
                    end else if (r_idx == SUM_HI_WORD) begin
                        n_rdata = w_summary[63:32];
                    end
                end
                OP_WRITE: begin
                    if (w_pin_ok) begin
                        n_sts[w_pin] = w_wr_sts;
                        n_dlv[w_pin] = r_wd[B_DELIVER];
                        w_wr.en      = 1'b1;
                        w_wr.addr    = w_pin;
                        w_wr.data    = w_wr_word;
                        if (!w_before && w_wr_sts && r_wd[B_DELIVER]) begin
                            n_irq = 1'b1;
                        end
                    end else if (r_idx == MASTER_WORD) begin
                        n_master        = r_wd;
                        n_master[B_EOI] = 1'b0;
                        if (r_wd[B_EOI]) begin
                            n_irq = |w_summary;
                        end
                    end
                end
                OP_EVENT: begin
                    if (w_pin_ok) begin
                        n_sts[w_pin] = w_ev_sts;
                        w_wr.en      = 1'b1;
                        w_wr.addr    = w_pin;
                        w_wr.data    = w_ev_word;
                        if (!w_before && w_ev_sts && w_dlv_c) begin
                            n_irq = 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sts    <= '0;
            r_dlv    <= '0;
            r_master <= '0;
            r_irq    <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_sts    <= n_sts;
            r_dlv    <= n_dlv;
            r_master <= n_master;
            r_irq    <= n_irq;
            r_strobe <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= n_rdata;
    end

    assign o_strobe    = r_strobe;
    assign o_read_data = r_rdata;
    assign o_irq       = r_irq;

`ifndef SYNTHESIS
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 |=> o_strobe)
        else $error("item in flight produced no result");

    a_irq_rise_on_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_irq) |-> o_strobe)
        else $error("irq rose outside a result cycle");

    a_irq_fall_on_eoi: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($fell(o_irq) && $past(i_rst_n)) |-> (o_strobe && ($past(r_op) == OP_WRITE)
            && ($past(r_idx) == MASTER_WORD) && $past(r_wd[B_EOI])))
        else $error("irq cleared without end-of-interrupt");

    a_nonread_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && ($past(r_op) != OP_READ)) |-> (o_read_data == 32'd0))
        else $error("non-read item returned data");

    a_pending_summary: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_summary != 64'd0) |-> r_irq)
        else $error("delivered status without host interrupt");
`endif

endmodule
`default_nettype wire
